// ===== rtl/lfr_pkg.sv =====
package lfr_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_W = 16;
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] HEAD_RESET = 8'd170;
  localparam logic [7:0] TAIL_RESET = 8'd85;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_READ    = 2'd2
  } lfr_action_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4
  } lfr_phase_t;

  typedef struct packed {
    logic             accepted;
    logic             frame_done;
    logic             message_held;
    logic [LEN_W-1:0] frame_length;
  } lfr_status_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } lfr_wr_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } lfr_rd_req_t;

endpackage

// ===== rtl/length_framed_message_receiver.sv =====
// a result is registered in stage one and then in the output stage after its word is taken
// throughput: one word per cycle while in_stall is low; the payload store has a single
// registered read port and a write port, and each word uses at most one of them
// reset clears phase, count, length, the held flag and both stages; the payload
// store is not cleared, reads are gated by the stored count
module length_framed_message_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        frame_done,
  output logic        message_held,
  output logic [15:0] frame_length,
  output logic [7:0]  read_data
);
  import lfr_pkg::*;

  lfr_status_t status, s1_status;
  lfr_wr_req_t wr;
  lfr_rd_req_t rd;
  logic        fire, s1_valid, s1_adv;
  logic [7:0]  buf_data;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign fire     = in_valid && !in_stall;

  lfr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fire       (fire),
    .action     (action),
    .data_byte  (data_byte),
    .read_index (read_index),
    .status     (status),
    .wr         (wr),
    .rd         (rd)
  );

  // a read never meets a write from the same word, and earlier writes have landed
  lfr_buffer u_buffer (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (fire),
    .rd        (rd),
    .read_data (buf_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      accepted     <= s1_status.accepted;
      frame_done   <= s1_status.frame_done;
      message_held <= s1_status.message_held;
      frame_length <= s1_status.frame_length;
      read_data    <= buf_data;
    end
  end

  a_done_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> message_held && accepted)
    else $error("frame completion without held message");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced word lost before output");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> read_data == 8'd0)
    else $error("read data on a byte word");

endmodule

// ===== rtl/lfr_buffer.sv =====
module lfr_buffer (
  input  logic               clk,
  input  lfr_pkg::lfr_wr_req_t wr,
  input  logic               rd_en,
  input  lfr_pkg::lfr_rd_req_t rd,
  output logic [7:0]         read_data
);
  import lfr_pkg::*;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] q;
  logic       ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // q only moves when a new word enters, so it holds while the result waits
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok <= rd.ok;
      if (rd.ok) begin
        q <= mem[rd.addr];
      end
    end
  end

  // entries at or beyond the stored count read as zero
  assign read_data = ok ? q : 8'd0;

endmodule

// ===== rtl/lfr_parser.sv =====
module lfr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 fire,
  input  logic [1:0]           action,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           read_index,
  output lfr_pkg::lfr_status_t status,
  output lfr_pkg::lfr_wr_req_t wr,
  output lfr_pkg::lfr_rd_req_t rd
);
  import lfr_pkg::*;

  logic [7:0]       head_byte;
  logic [7:0]       tail_byte;
  lfr_phase_t       phase, phase_next;
  logic [CNT_W-1:0] count, count_next;
  logic [LEN_W-1:0] length, length_next;
  logic             held, held_next;

  logic take, release_ok, is_tail, cnt_eq, cnt_gt, full, done;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
      tail_byte <= TAIL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD: head_byte <= cfg_data;
        REG_TAIL: tail_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      count  <= '0;
      length <= '0;
      held   <= 1'b0;
    end else begin
      phase  <= phase_next;
      count  <= count_next;
      length <= length_next;
      held   <= held_next;
    end
  end

  assign take       = fire && (action == ACT_BYTE) && !held;
  assign release_ok = fire && (action == ACT_RELEASE) && held;
  assign is_tail    = (data_byte == tail_byte);
  assign cnt_eq     = (CMP_W'(count) == CMP_W'(length));
  assign cnt_gt     = (CMP_W'(count) > CMP_W'(length));
  assign full       = (CMP_W'(count) >= CMP_W'(BUFFER_DEPTH));

  // next phase
  always_comb begin
    phase_next = phase;
    if (release_ok) begin
      phase_next = PH_HUNT;
    end else if (take) begin
      case (phase)
        PH_HUNT: begin
          if (data_byte == head_byte) phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: phase_next = PH_PAYLOAD;
        PH_PAYLOAD: begin
          if (is_tail && cnt_eq) phase_next = PH_DONE;
          else if (is_tail && cnt_gt) phase_next = PH_HUNT;
          else if (full) phase_next = PH_HUNT;
        end
        default: phase_next = phase;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    count_next  = count;
    length_next = length;
    held_next   = held;
    done        = 1'b0;
    wr.en       = 1'b0;
    wr.addr     = ADDR_W'(count);
    wr.data     = data_byte;
    if (release_ok) begin
      held_next  = 1'b0;
      count_next = '0;
    end else if (take) begin
      case (phase)
        PH_HUNT: begin
          if (data_byte == head_byte) begin
            count_next  = '0;
            length_next = '0;
          end
        end
        PH_LEN_HI: length_next = {data_byte, 8'd0};
        PH_LEN_LO: length_next = {length[LEN_W-1:8], data_byte};
        PH_PAYLOAD: begin
          if (is_tail && cnt_eq) begin
            held_next = 1'b1;
            done      = 1'b1;
          end else if (is_tail && cnt_gt) begin
            count_next  = '0;
            length_next = '0;
          end else if (!full) begin
            wr.en      = 1'b1;
            count_next = CNT_W'(count + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  assign status.accepted     = take;
  assign status.frame_done   = done;
  assign status.message_held = held_next;
  assign status.frame_length = length_next;

  assign rd.ok   = (action == ACT_READ)
                   && (CMP_W'(read_index) < CMP_W'(count))
                   && (CMP_W'(read_index) < CMP_W'(BUFFER_DEPTH));
  assign rd.addr = ADDR_W'(read_index);

endmodule
